FILE: sv/bfkr_pkg.sv
// bfkr_pkg: request/status codes, register indexes and reset constants
// for the keyed-removal tag queue. No dependencies.
package bfkr_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_RM_KEY = 3'd2,
        REQ_RM_POS = 3'd3,
        REQ_EXPAND = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_POS   = 3'd4,
        ST_NO_EXPAND = 3'd5
    } status_t;

    // configuration register indexes
    localparam int  CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CAP  = 1'b1;

    // register values after reset
    localparam int RST_INIT_CAP = 64;
    localparam int RST_MAX_CAP  = 64;

endpackage

FILE: sv/bfkr_ram.sv
// bfkr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bfkr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/bounded_fifo_with_keyed_removal.sv
// bounded_fifo_with_keyed_removal: ordered tag queue with run-time capacity,
// pop, remove by key, remove at position and expand. Uses bfkr_pkg, bfkr_ram.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+---------------------------------------
//  in      | to block  | in_valid/in_stall  | req_type, tag, position
//  out     | from block| out_valid/out_stall| status, removed_tag, count,
//          |           |                    | capacity_now, is_empty, is_full, can_expand
//  cfg     | to block  | cfg_we             | cfg_addr, cfg_wdata
//
// Entries sit packed in one RAM, oldest at address 0; one word in flight at a time.
// Push, expand and rejected requests pass through S_FIN to the output register.
// Pop / remove at position p: S_TAKE takes entry p, then S_SHIFT moves the younger
// entries down one entry per cycle through the RAM's registered read port and write port.
// Remove by key first compares entries in S_SCAN, oldest first, and shifts from the match.
// No clearing pass after reset; in_stall is high while a word is being worked
// and while a finished result waits for a full output register to drain.
module bounded_fifo_with_keyed_removal
    import bfkr_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 req_type,
    input  logic [TAG_BITS-1:0]        tag,
    input  logic [$clog2(DEPTH)-1:0]   position,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [TAG_BITS-1:0]        removed_tag,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic [$clog2(DEPTH+1)-1:0] capacity_now,
    output logic                       is_empty,
    output logic                       is_full,
    output logic                       can_expand,
    // configuration
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_addr,
    input  logic [$clog2(DEPTH+1)-1:0] cfg_wdata
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH+1);
    localparam int CAP_RST = (RST_INIT_CAP == 0) ? 1 :
                             ((RST_INIT_CAP > DEPTH) ? DEPTH : RST_INIT_CAP);
    localparam int MAX_RST = (RST_MAX_CAP > DEPTH) ? DEPTH : RST_MAX_CAP;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAKE,
        S_SHIFT,
        S_FIN
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [CNT_W-1:0]      cap_reg, cap_next;
    logic [CNT_W-1:0]      max_reg, max_next;     // already limited to DEPTH
    logic [CNT_W-1:0]      idx_reg, idx_next;     // address whose data is on ram_rdata
    logic [TAG_BITS-1:0]   key_reg, key_next;
    logic [TAG_BITS-1:0]   rem_reg, rem_next;
    status_t               stat_reg, stat_next;

    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            status_reg, status_next;
    logic [TAG_BITS-1:0]   removed_tag_reg, removed_tag_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      capacity_now_reg, capacity_now_next;
    logic                  is_empty_reg, is_empty_next;
    logic                  is_full_reg, is_full_next;
    logic                  can_expand_reg, can_expand_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [TAG_BITS-1:0]   ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [TAG_BITS-1:0]   ram_rdata;

    logic [CNT_W-1:0]      idx_inc;
    logic [CNT_W-1:0]      pos_ext;

    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > CNT_W'(DEPTH))
        begin
            r = CNT_W'(DEPTH);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    bfkr_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_inc = idx_reg + CNT_W'(1);
    assign pos_ext = CNT_W'(position);

    always_comb
    begin
        state_next        = state_reg;
        occ_next          = occ_reg;
        cap_next          = cap_reg;
        max_next          = max_reg;
        idx_next          = idx_reg;
        key_next          = key_reg;
        rem_next          = rem_reg;
        stat_next         = stat_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        removed_tag_next  = removed_tag_reg;
        count_next        = count_reg;
        capacity_now_next = capacity_now_reg;
        is_empty_next     = is_empty_reg;
        is_full_next      = is_full_reg;
        can_expand_next   = can_expand_reg;

        ram_we    = 1'b0;
        ram_waddr = occ_reg[AW-1:0];
        ram_wdata = tag;
        ram_raddr = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    stat_next  = ST_OK;
                    rem_next   = '0;
                    key_next   = tag;
                    state_next = S_FIN;
                    unique case (req_t'(req_type))
                        REQ_PUSH:
                        begin
                            if (occ_reg >= cap_reg)
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        REQ_POP:
                        begin
                            if (occ_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_TAKE;
                            end
                        end
                        REQ_RM_KEY:
                        begin
                            if (occ_reg == '0)
                            begin
                                stat_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_RM_POS:
                        begin
                            if (occ_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else if (pos_ext >= occ_reg)
                            begin
                                stat_next = ST_BAD_POS;
                            end
                            else
                            begin
                                ram_raddr  = position;
                                idx_next   = pos_ext;
                                state_next = S_TAKE;
                            end
                        end
                        REQ_EXPAND:
                        begin
                            if (cap_reg < max_reg)
                            begin
                                cap_next = cap_reg + CNT_W'(1);
                            end
                            else
                            begin
                                stat_next = ST_NO_EXPAND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (ram_rdata == key_reg)
                begin
                    rem_next = ram_rdata;
                    if (idx_inc < occ_reg)
                    begin
                        ram_raddr  = idx_inc[AW-1:0];
                        idx_next   = idx_inc;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        occ_next   = occ_reg - CNT_W'(1);
                        state_next = S_FIN;
                    end
                end
                else if (idx_inc < occ_reg)
                begin
                    ram_raddr = idx_inc[AW-1:0];
                    idx_next  = idx_inc;
                end
                else
                begin
                    stat_next  = ST_NOT_FOUND;
                    state_next = S_FIN;
                end
            end

            S_TAKE, S_SHIFT:
            begin
                if (state_reg == S_TAKE)
                begin
                    rem_next = ram_rdata;
                end
                else
                begin
                    // move the younger neighbor down one slot
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[AW-1:0] - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (idx_inc < occ_reg)
                begin
                    ram_raddr  = idx_inc[AW-1:0];
                    idx_next   = idx_inc;
                    state_next = S_SHIFT;
                end
                else
                begin
                    occ_next   = occ_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = stat_reg;
                    removed_tag_next  = rem_reg;
                    count_next        = occ_reg;
                    capacity_now_next = cap_reg;
                    is_empty_next     = (occ_reg == '0);
                    is_full_next      = (occ_reg >= cap_reg);
                    can_expand_next   = (cap_reg < max_reg);
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_addr == CFG_INIT_CAP)
            begin
                cap_next = clamp_cap(cfg_wdata);
            end
            else if (cfg_addr == CFG_MAX_CAP)
            begin
                max_next = (cfg_wdata > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            occ_reg          <= '0;
            cap_reg          <= CNT_W'(CAP_RST);
            max_reg          <= CNT_W'(MAX_RST);
            idx_reg          <= '0;
            key_reg          <= '0;
            rem_reg          <= '0;
            stat_reg         <= ST_OK;
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            removed_tag_reg  <= '0;
            count_reg        <= '0;
            capacity_now_reg <= '0;
            is_empty_reg     <= 1'b0;
            is_full_reg      <= 1'b0;
            can_expand_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            occ_reg          <= occ_next;
            cap_reg          <= cap_next;
            max_reg          <= max_next;
            idx_reg          <= idx_next;
            key_reg          <= key_next;
            rem_reg          <= rem_next;
            stat_reg         <= stat_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            removed_tag_reg  <= removed_tag_next;
            count_reg        <= count_next;
            capacity_now_reg <= capacity_now_next;
            is_empty_reg     <= is_empty_next;
            is_full_reg      <= is_full_next;
            can_expand_reg   <= can_expand_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign removed_tag  = removed_tag_reg;
    assign count        = count_reg;
    assign capacity_now = capacity_now_reg;
    assign is_empty     = is_empty_reg;
    assign is_full      = is_full_reg;
    assign can_expand   = can_expand_reg;

    // occupancy never exceeds the RAM
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // live capacity stays within 1..DEPTH
    a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_reg != '0) && (cap_reg <= CNT_W'(DEPTH)))
        else $error("capacity out of range");

    // while the shift keeps reading ahead, it never reads the slot it writes
    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_SHIFT) && (idx_inc < occ_reg))
        |-> (ram_waddr != ram_raddr))
        else $error("shift read/write collision");

    // walking states only run on a non-empty queue
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) || (state_reg == S_TAKE) || (state_reg == S_SHIFT))
        |-> (occ_reg != '0))
        else $error("walk on empty queue");

    // occupancy moves by at most one per step
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |->
        ((occ_reg == $past(occ_reg) + CNT_W'(1)) || (occ_reg + CNT_W'(1) == $past(occ_reg))))
        else $error("occupancy jumped");

endmodule
